// ----- sv/mruc_pkg.sv -----
// ----------------------------------------------------------------------------
// mruc_pkg: shared types and constants for the pinned mru image cache
// table geometry, request and response formats, status codes
// ----------------------------------------------------------------------------
package mruc_pkg;

  // table geometry
  localparam int ENTRIES = 16;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int IDX_W   = SLOT_W + 1;
  localparam int TOTAL   = 2 * ENTRIES;
  localparam int KEY_W   = 32;
  localparam int REF_W   = 16;
  localparam int RANK_W  = SLOT_W;
  localparam int SC_W    = 5;

  localparam logic [SC_W-1:0]  SAVE_RESET = SC_W'(5);
  localparam logic [REF_W-1:0] REF_MAX    = {REF_W{1'b1}};

  // request kinds
  localparam logic KIND_GET     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // image types
  localparam logic [1:0] TYPE_BRUSH = 2'd0;
  localparam logic [1:0] TYPE_LAYER = 2'd2;

  // response status codes
  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_NO_IMAGE = 3'd2;
  localparam logic [2:0] STAT_LOAD_ERR = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_RELEASED = 3'd5;
  localparam logic [2:0] STAT_REL_MISS = 3'd6;

  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    logic             kind;
    logic [1:0]       image_type;
    logic [KEY_W-1:0] key;
    logic             key_empty;
    logic             keep;
    logic             load_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       slot;
    logic [REF_W-1:0] ref_count;
    logic [15:0]      evicted_mask;
  } rsp_t;

  // eviction planner status toward the sequencer
  typedef struct packed {
    logic            done;
    logic [CNT_W-1:0] gone_cnt;
  } plan_stat_t;

endpackage

// ----- sv/mruc_evict_plan.sv -----
// ----------------------------------------------------------------------------
// mruc_evict_plan: eviction planner
// walks the recency order one rank a cycle, marks evicted ranks and builds
// the compacted rank of every kept rank
// ----------------------------------------------------------------------------
module mruc_evict_plan (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [mruc_pkg::ENTRIES-1:0]         zero_by_rank_i,
  input  logic [mruc_pkg::SC_W-1:0]            save_count_i,
  output logic [mruc_pkg::ENTRIES-1:0]         gone_by_rank_o,
  output mruc_pkg::rank_t [mruc_pkg::ENTRIES-1:0] remap_o,
  output mruc_pkg::plan_stat_t                 stat_o
);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [mruc_pkg::SLOT_W-1:0]  r_q, r_d;
  logic [mruc_pkg::CNT_W-1:0]   zc_q, zc_d;
  logic [mruc_pkg::CNT_W-1:0]   gc_q, gc_d;
  logic [mruc_pkg::ENTRIES-1:0] gone_q;
  mruc_pkg::rank_t [mruc_pkg::ENTRIES-1:0] remap_q;
  logic [mruc_pkg::SC_W-1:0]    eff_sc;
  logic                         z_now;
  logic                         g_now;
  logic                         last;

  // a save count of zero behaves as one
  assign eff_sc = (save_count_i == '0) ? mruc_pkg::SC_W'(1) : save_count_i;
  assign z_now  = zero_by_rank_i[r_q];
  assign g_now  = z_now &&
                  ((mruc_pkg::SC_W+1)'(zc_q) + (mruc_pkg::SC_W+1)'(1) >=
                   (mruc_pkg::SC_W+1)'(eff_sc));
  assign last   = (r_q == mruc_pkg::SLOT_W'(mruc_pkg::ENTRIES - 1));

  // rank walk control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    r_d    = r_q;
    zc_d   = zc_q;
    gc_d   = gc_q;
    if (start_i) begin
      busy_d = 1'b1;
      r_d    = '0;
      zc_d   = '0;
      gc_d   = '0;
    end else if (busy_q) begin
      zc_d = zc_q + mruc_pkg::CNT_W'(z_now);
      gc_d = gc_q + mruc_pkg::CNT_W'(g_now);
      r_d  = r_q + mruc_pkg::SLOT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      r_q    <= '0;
      zc_q   <= '0;
      gc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      r_q    <= r_d;
      zc_q   <= zc_d;
      gc_q   <= gc_d;
    end
  end

  // per-rank plan, overwritten rank by rank on every walk
  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) begin
      gone_q[r_q]  <= g_now;
      remap_q[r_q] <= r_q - gc_q[mruc_pkg::SLOT_W-1:0];
    end
  end

  assign gone_by_rank_o  = gone_q;
  assign remap_o         = remap_q;
  assign stat_o.done     = done_q;
  assign stat_o.gone_cnt = gc_q;

endmodule

// ----- sv/mru_cache_with_pinning.sv -----
// ----------------------------------------------------------------------------
// mru_cache_with_pinning: two mru image tables with reference-count pinning
// brush table and texture table, lookup, pin, release and eviction sequencer
// ----------------------------------------------------------------------------
// One request is worked at a time; the request port stalls until its response
// is handed to the output register. Every request with a key walks the 16 slots
// of its table through a single key comparator, one slot a cycle. An empty key
// goes straight to the response; a release, a load failure or a miss answers
// after the lookup walk, a hit after the lookup walk and a recency update walk,
// and an insertion after the lookup walk, a walk of the recency order that plans
// the eviction, a wait for the plan to settle, and a slot walk that evicts,
// compacts ranks and inserts. A full table with nothing to evict answers after
// the planning walk, and output stalls hold the response back. The save
// count register may be written at any time the block is idle; there is no
// reset clearing pass.
module mru_cache_with_pinning (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mruc_pkg::req_t            in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mruc_pkg::rsp_t            out_rsp_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mruc_pkg::SC_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_PLAN  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_MOVE  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam int SW = mruc_pkg::SLOT_W;
  localparam int RW = mruc_pkg::REF_W;
  localparam int NE = mruc_pkg::ENTRIES;

  // table storage
  logic [mruc_pkg::KEY_W-1:0] key_mem  [mruc_pkg::TOTAL];
  mruc_pkg::rank_t            rank_mem [mruc_pkg::TOTAL];
  logic [mruc_pkg::TOTAL-1:0] valid_q;
  logic [RW-1:0]              refs_q   [mruc_pkg::TOTAL];

  // sequencer registers
  logic [2:0]               state_q, state_d;
  mruc_pkg::req_t           req_q, req_d;
  logic [SW-1:0]            cnt_q, cnt_d;
  logic                     hit_q, hit_d;
  logic [SW-1:0]            hit_slot_q, hit_slot_d;
  logic [RW-1:0]            hit_refs_q, hit_refs_d;
  mruc_pkg::rank_t          hit_rank_q, hit_rank_d;
  logic [mruc_pkg::CNT_W-1:0] nvalid_q, nvalid_d;
  logic [NE-1:0]            zmask_q, zmask_d;
  logic                     ins_done_q, ins_done_d;
  logic [SW-1:0]            ins_slot_q, ins_slot_d;
  logic [15:0]              mask_q, mask_d;
  mruc_pkg::rsp_t           res_q, res_d;
  logic                     out_valid_q, out_valid_d;
  mruc_pkg::rsp_t           out_rsp_q, out_rsp_d;
  logic [mruc_pkg::SC_W-1:0] save_count_q;

  // storage write controls
  logic [mruc_pkg::IDX_W-1:0] wr_idx;
  logic                       key_we, valid_we, refs_we, rank_we;
  logic                       valid_wd;
  logic [RW-1:0]              refs_wd;
  mruc_pkg::rank_t            rank_wd;

  // planner
  logic                       plan_start;
  logic [NE-1:0]              gone_by_rank;
  mruc_pkg::rank_t [NE-1:0]   remap;
  mruc_pkg::plan_stat_t       plan_stat;

  // walk read port and derived values
  logic                       tbl;
  logic                       bump_req;
  logic [mruc_pkg::IDX_W-1:0] widx;
  logic [mruc_pkg::KEY_W-1:0] rd_key;
  logic                       rd_valid;
  logic [RW-1:0]              rd_refs;
  mruc_pkg::rank_t            rd_rank;
  logic                       last;
  logic                       match;
  logic                       hit_now;
  logic [SW-1:0]              slot_now;
  logic [RW-1:0]              refs_now;
  logic [RW-1:0]              refs_dec;
  logic [RW-1:0]              refs_bumped;
  logic [RW-1:0]              refs_new;
  logic                       gone_now;
  logic                       free_now;
  logic                       out_free;
  logic [15:0]                slot_bit;

  assign tbl      = (req_q.image_type == mruc_pkg::TYPE_BRUSH);
  assign bump_req = (req_q.image_type == mruc_pkg::TYPE_LAYER) || req_q.keep;
  assign widx     = {tbl, cnt_q};
  assign rd_key   = key_mem[widx];
  assign rd_valid = valid_q[widx];
  assign rd_refs  = refs_q[widx];
  assign rd_rank  = rank_mem[widx];
  assign last     = (cnt_q == SW'(NE - 1));

  // shared key compare and per-slot decode
  assign match    = rd_valid && (rd_key == req_q.key);
  assign hit_now  = hit_q || match;
  assign slot_now = hit_q ? hit_slot_q : cnt_q;
  assign refs_now = hit_q ? hit_refs_q : rd_refs;
  assign refs_dec = refs_now - RW'(refs_now != '0);
  assign refs_bumped = (bump_req && (hit_refs_q != mruc_pkg::REF_MAX)) ?
                       hit_refs_q + RW'(1) : hit_refs_q;
  assign refs_new = RW'(bump_req);
  assign gone_now = rd_valid && gone_by_rank[rd_rank];
  assign free_now = !rd_valid || gone_now;
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_bit = 16'(1) << cnt_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    hit_slot_d  = hit_slot_q;
    hit_refs_d  = hit_refs_q;
    hit_rank_d  = hit_rank_q;
    nvalid_d    = nvalid_q;
    zmask_d     = zmask_q;
    ins_done_d  = ins_done_q;
    ins_slot_d  = ins_slot_q;
    mask_d      = mask_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    plan_start  = 1'b0;
    wr_idx      = widx;
    key_we      = 1'b0;
    valid_we    = 1'b0;
    valid_wd    = 1'b0;
    refs_we     = 1'b0;
    refs_wd     = refs_new;
    rank_we     = 1'b0;
    rank_wd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_req_i;
          cnt_d      = '0;
          hit_d      = 1'b0;
          nvalid_d   = '0;
          zmask_d    = '0;
          mask_d     = '0;
          res_d      = '0;
          if (in_req_i.key_empty) begin
            res_d.status = mruc_pkg::STAT_NO_IMAGE;
            state_d      = ST_EMIT;
          end else begin
            state_d = ST_LOOK;
          end
        end
      end
      // lookup walk, also gathers the unpinned-by-rank map
      ST_LOOK: begin
        cnt_d = cnt_q + SW'(1);
        if (match && !hit_q) begin
          hit_d      = 1'b1;
          hit_slot_d = cnt_q;
          hit_refs_d = rd_refs;
          hit_rank_d = rd_rank;
        end
        if (rd_valid) begin
          nvalid_d = nvalid_q + mruc_pkg::CNT_W'(1);
          if (rd_refs == '0) zmask_d[rd_rank] = 1'b1;
        end
        if (last) begin
          cnt_d = '0;
          if (req_q.kind == mruc_pkg::KIND_RELEASE) begin
            state_d = ST_EMIT;
            if (hit_now) begin
              wr_idx          = {tbl, slot_now};
              refs_we         = 1'b1;
              refs_wd         = refs_dec;
              res_d.status    = mruc_pkg::STAT_RELEASED;
              res_d.slot      = 4'(slot_now);
              res_d.ref_count = refs_dec;
            end else begin
              res_d.status = mruc_pkg::STAT_REL_MISS;
            end
          end else if (hit_now) begin
            state_d = ST_MOVE;
          end else if (!req_q.load_ok) begin
            res_d.status = mruc_pkg::STAT_LOAD_ERR;
            state_d      = ST_EMIT;
          end else begin
            plan_start = 1'b1;
            state_d    = ST_PLAN;
          end
        end
      end
      // wait for the eviction plan, then check for a full table with nothing to evict
      ST_PLAN: begin
        if (plan_stat.done) begin
          if ((nvalid_q == mruc_pkg::CNT_W'(NE)) && (plan_stat.gone_cnt == '0)) begin
            res_d.status = mruc_pkg::STAT_FULL;
            state_d      = ST_EMIT;
          end else begin
            ins_done_d = 1'b0;
            state_d    = ST_SWEEP;
          end
        end
      end
      // evict, compact ranks behind the new front entry, insert at first free
      ST_SWEEP: begin
        cnt_d = cnt_q + SW'(1);
        if (gone_now) mask_d = mask_q | slot_bit;
        if (!ins_done_q && free_now) begin
          key_we     = 1'b1;
          valid_we   = 1'b1;
          valid_wd   = 1'b1;
          refs_we    = 1'b1;
          refs_wd    = refs_new;
          rank_we    = 1'b1;
          rank_wd    = '0;
          ins_done_d = 1'b1;
          ins_slot_d = cnt_q;
        end else if (gone_now) begin
          valid_we = 1'b1;
          valid_wd = 1'b0;
        end else if (rd_valid) begin
          rank_we = 1'b1;
          rank_wd = remap[rd_rank] + mruc_pkg::RANK_W'(1);
        end
        if (last) begin
          cnt_d              = '0;
          res_d.status       = mruc_pkg::STAT_INSERTED;
          res_d.slot         = 4'(ins_done_q ? ins_slot_q : cnt_q);
          res_d.ref_count    = refs_new;
          res_d.evicted_mask = gone_now ? (mask_q | slot_bit) : mask_q;
          state_d            = ST_EMIT;
        end
      end
      // move the hit entry to the front and pin it if the request keeps it or is a layer
      ST_MOVE: begin
        cnt_d = cnt_q + SW'(1);
        if (cnt_q == hit_slot_q) begin
          rank_we = 1'b1;
          rank_wd = '0;
          refs_we = 1'b1;
          refs_wd = refs_bumped;
        end else if (rd_valid && (rd_rank < hit_rank_q)) begin
          rank_we = 1'b1;
          rank_wd = rd_rank + mruc_pkg::RANK_W'(1);
        end
        if (last) begin
          cnt_d           = '0;
          res_d.status    = mruc_pkg::STAT_HIT;
          res_d.slot      = 4'(hit_slot_q);
          res_d.ref_count = refs_bumped;
          state_d         = ST_EMIT;
        end
      end
      // hand the response to the output register
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rsp_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      ins_done_q   <= 1'b0;
      cnt_q        <= '0;
      save_count_q <= mruc_pkg::SAVE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      ins_done_q  <= ins_done_d;
      cnt_q       <= cnt_d;
      if (cfg_valid_i) save_count_q <= cfg_data_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    hit_slot_q <= hit_slot_d;
    hit_refs_q <= hit_refs_d;
    hit_rank_q <= hit_rank_d;
    nvalid_q   <= nvalid_d;
    zmask_q    <= zmask_d;
    ins_slot_q <= ins_slot_d;
    mask_q     <= mask_d;
    res_q      <= res_d;
    out_rsp_q  <= out_rsp_d;
  end

  // valid bits and reference counts, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < mruc_pkg::TOTAL; i++) refs_q[i] <= '0;
    end else begin
      if (valid_we) valid_q[wr_idx] <= valid_wd;
      if (refs_we)  refs_q[wr_idx]  <= refs_wd;
    end
  end

  // keys and recency ranks, meaningful only while valid
  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[wr_idx]  <= req_q.key;
    if (rank_we) rank_mem[wr_idx] <= rank_wd;
  end

  mruc_evict_plan u_plan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (plan_start),
    .zero_by_rank_i (zmask_q),
    .save_count_i   (save_count_q),
    .gone_by_rank_o (gone_by_rank),
    .remap_o        (remap),
    .stat_o         (plan_stat)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign cfg_ready_o = 1'b1;

  // the full check guarantees a free slot by the end of the sweep
  a_sweep_inserts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && last) |-> (ins_done_q || free_now))
    else $error("sweep ended without an insertion slot");

  // the recency update walk only follows a lookup hit
  a_move_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> hit_q)
    else $error("recency update without a hit");

  // evictions only show on an insertion
  a_mask_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.evicted_mask != '0)) |->
    (out_rsp_o.status == mruc_pkg::STAT_INSERTED))
    else $error("evicted mask set on a response other than an insertion");

endmodule
